// File: sv/spq_pkg.sv
// Shared types and constants for the stable priority queue.
// No dependencies.
package spq_pkg;

  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned PRIO_WIDTH_DEF = 16;

  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISP,
    S_CMP,
    S_PUT,
    S_POP,
    S_DONE
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture request, resolve priority
    logic rd_scan;  // read entry pos-1
    logic shift;    // move read entry to pos, read pos-2
    logic put;      // write new entry at pos
    logic rd_front; // read front entry
    logic pop;      // take front entry
    logic finish;   // move result into output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic deq;
    logic full;
    logic empty;
    logic ge;
    logic last;
    logic out_busy;
  } sts_t;

endpackage

// File: sv/spq_req_if.sv
// Request channel of the priority queue: valid/ready plus item fields.
// Depends on spq_pkg.
interface spq_req_if import spq_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int unsigned PRIO_WIDTH = PRIO_WIDTH_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic [DATA_WIDTH-1:0] payload;
  logic [PRIO_WIDTH-1:0] prio;
  logic                  auto_prio;

  modport source (output valid, kind, payload, prio, auto_prio, input ready);
  modport sink   (input valid, kind, payload, prio, auto_prio, output ready);
endinterface

// File: sv/spq_rsp_if.sv
// Response channel of the priority queue: valid/ready plus result fields.
// Depends on spq_pkg.
interface spq_rsp_if import spq_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int unsigned PRIO_WIDTH = PRIO_WIDTH_DEF,
  parameter int unsigned OCC_WIDTH  = $clog2(DEPTH_DEF + 1)
);
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] out_payload;
  logic [1:0]            status;
  logic [PRIO_WIDTH-1:0] used_prio;
  logic [OCC_WIDTH-1:0]  occupancy;

  modport source (output valid, out_payload, status, used_prio, occupancy, input ready);
  modport sink   (input valid, out_payload, status, used_prio, occupancy, output ready);
endinterface

// File: sv/stable_priority_queue.sv
// Stable priority queue: one request at a time. A dequeue pops the front entry; an
// enqueue moves each entry of lower priority back one place (one RAM read and write
// each) and writes the new entry behind those of equal or higher priority. A result
// is loaded into the output register in S_DONE once an earlier one has been taken;
// only then is the next request accepted. Async active-low reset empties the queue
// and clears the tracked maximum.
module stable_priority_queue import spq_pkg::*; #(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int unsigned PRIO_WIDTH = PRIO_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  spq_req_if.sink   req_i,
  spq_rsp_if.source rsp_o
);

  localparam int unsigned OCC_WIDTH = $clog2(DEPTH + 1);

  cmd_t cmd;
  sts_t sts;

  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  spq_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .PRIO_WIDTH (PRIO_WIDTH),
    .OCC_WIDTH  (OCC_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .kind_i        (req_i.kind),
    .payload_i     (req_i.payload),
    .prio_i        (req_i.prio),
    .auto_prio_i   (req_i.auto_prio),
    .rsp_valid_o   (rsp_o.valid),
    .rsp_ready_i   (rsp_o.ready),
    .out_payload_o (rsp_o.out_payload),
    .status_o      (rsp_o.status),
    .used_prio_o   (rsp_o.used_prio),
    .occupancy_o   (rsp_o.occupancy)
  );

  a_empty_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status == ST_EMPTY) |-> (rsp_o.occupancy == '0))
    else $error("empty status with nonzero occupancy");

  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status == ST_FULL)
      |-> (rsp_o.occupancy == OCC_WIDTH'(DEPTH)))
    else $error("full status below capacity");

  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request accepted while another is in flight");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> !(rsp_o.valid && !rsp_o.ready))
    else $error("result overwritten before it was taken");

endmodule

// File: sv/spq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module spq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: sv/spq_ctrl.sv
// Sequencer of the priority queue: accepts requests, steps the datapath
// through the insertion scan or the front removal. Depends on spq_pkg.
module spq_ctrl import spq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) state_d = S_DISP;
      end
      S_DISP: begin
        if (sts_i.deq) begin
          state_d = sts_i.empty ? S_DONE : S_POP;
        end else if (sts_i.full) begin
          state_d = S_DONE;
        end else if (sts_i.empty) begin
          state_d = S_PUT;
        end else begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (sts_i.ge || sts_i.last) state_d = S_PUT;
      end
      S_PUT:  state_d = S_DONE;
      S_POP:  state_d = S_DONE;
      S_DONE: begin
        if (!sts_i.out_busy) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        cmd_o.load  = req_valid_i;
      end
      S_DISP: begin
        if (sts_i.deq) begin
          cmd_o.rd_front = !sts_i.empty;
        end else begin
          cmd_o.rd_scan = !sts_i.full && !sts_i.empty;
        end
      end
      S_CMP:  cmd_o.shift  = !sts_i.ge;
      S_PUT:  cmd_o.put    = 1'b1;
      S_POP:  cmd_o.pop    = 1'b1;
      S_DONE: cmd_o.finish = !sts_i.out_busy;
      default: ;
    endcase
  end

endmodule

// File: sv/spq_dp.sv
// Datapath of the priority queue: entry RAM as a ring, head and count,
// tracked maximum, working result and output register. Depends on spq_pkg, spq_ram.
module spq_dp import spq_pkg::*; #(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int unsigned PRIO_WIDTH = PRIO_WIDTH_DEF,
  parameter int unsigned OCC_WIDTH  = $clog2(DEPTH + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o,
  input  logic                  kind_i,
  input  logic [DATA_WIDTH-1:0] payload_i,
  input  logic [PRIO_WIDTH-1:0] prio_i,
  input  logic                  auto_prio_i,
  output logic                  rsp_valid_o,
  input  logic                  rsp_ready_i,
  output logic [DATA_WIDTH-1:0] out_payload_o,
  output logic [1:0]            status_o,
  output logic [PRIO_WIDTH-1:0] used_prio_o,
  output logic [OCC_WIDTH-1:0]  occupancy_o
);

  localparam int unsigned IDXW  = $clog2(DEPTH);
  localparam int unsigned WORDW = PRIO_WIDTH + DATA_WIDTH;

  logic                  kind_q;
  logic [DATA_WIDTH-1:0] data_q;
  logic [PRIO_WIDTH-1:0] p_q, p_d;
  logic [OCC_WIDTH-1:0]  pos_q;
  logic [IDXW-1:0]       head_q;
  logic [OCC_WIDTH-1:0]  count_q;
  logic [PRIO_WIDTH-1:0] max_q;
  status_e               res_status_q, res_status_d;
  logic [DATA_WIDTH-1:0] res_payload_q;
  logic [PRIO_WIDTH-1:0] res_prio_q;
  logic                  rsp_valid_q;
  logic [DATA_WIDTH-1:0] rsp_payload_q;
  logic [1:0]            rsp_status_q;
  logic [PRIO_WIDTH-1:0] rsp_prio_q;
  logic [OCC_WIDTH-1:0]  rsp_occ_q;

  logic                  we;
  logic [IDXW-1:0]       waddr, raddr, pos_idx;
  logic [WORDW-1:0]      wdata, rdata;
  logic [PRIO_WIDTH-1:0] rd_prio;
  logic [DATA_WIDTH-1:0] rd_data;
  logic                  full, empty;

  function automatic logic [IDXW-1:0] phys(input logic [IDXW-1:0] head,
                                           input logic [IDXW-1:0] lidx);
    logic [IDXW:0] sum;
    sum = {1'b0, head} + {1'b0, lidx};
    if (sum >= (IDXW+1)'(DEPTH)) sum = sum - (IDXW+1)'(DEPTH);
    return sum[IDXW-1:0];
  endfunction

  assign pos_idx = pos_q[IDXW-1:0];
  assign rd_prio = rdata[WORDW-1:DATA_WIDTH];
  assign rd_data = rdata[DATA_WIDTH-1:0];
  assign full    = (count_q == OCC_WIDTH'(DEPTH));
  assign empty   = (count_q == '0);

  always_comb begin
    sts_o.deq      = (kind_q == KIND_DEQ);
    sts_o.full     = full;
    sts_o.empty    = empty;
    sts_o.ge       = (rd_prio >= p_q);
    sts_o.last     = (pos_q == OCC_WIDTH'(1));
    sts_o.out_busy = rsp_valid_q && !rsp_ready_i;
  end

  // RAM port steering
  always_comb begin
    we    = cmd_i.shift || cmd_i.put;
    waddr = phys(head_q, pos_idx);
    wdata = cmd_i.shift ? rdata : {p_q, data_q};
    if (cmd_i.rd_scan) begin
      raddr = phys(head_q, pos_idx - IDXW'(1));
    end else if (cmd_i.shift) begin
      raddr = phys(head_q, pos_idx - IDXW'(2));
    end else begin
      raddr = head_q;
    end
  end

  spq_ram #(
    .WIDTH (WORDW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    if (auto_prio_i) begin
      p_d = (max_q == '1) ? max_q : max_q + PRIO_WIDTH'(1);
    end else begin
      p_d = prio_i;
    end
    if (kind_i == KIND_DEQ) begin
      res_status_d = empty ? ST_EMPTY : ST_OK;
    end else begin
      res_status_d = full ? ST_FULL : ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      max_q       <= '0;
      rsp_valid_q <= 1'b0;
      kind_q      <= KIND_ENQ;
    end else begin
      if (cmd_i.load) kind_q <= kind_i;
      if (cmd_i.put) begin
        count_q <= count_q + OCC_WIDTH'(1);
        if (pos_q == '0 || p_q > max_q) max_q <= p_q;
      end
      if (cmd_i.pop) begin
        count_q <= count_q - OCC_WIDTH'(1);
        head_q  <= phys(head_q, IDXW'(1));
      end
      if (cmd_i.finish) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      data_q        <= payload_i;
      p_q           <= p_d;
      pos_q         <= count_q;
      res_status_q  <= res_status_d;
      res_payload_q <= '0;
      res_prio_q    <= '0;
    end
    if (cmd_i.shift) pos_q <= pos_q - OCC_WIDTH'(1);
    if (cmd_i.put)   res_prio_q <= p_q;
    if (cmd_i.pop)   res_payload_q <= rd_data;
    if (cmd_i.finish) begin
      rsp_payload_q <= res_payload_q;
      rsp_status_q  <= res_status_q;
      rsp_prio_q    <= res_prio_q;
      rsp_occ_q     <= count_q;
    end
  end

  assign rsp_valid_o   = rsp_valid_q;
  assign out_payload_o = rsp_payload_q;
  assign status_o      = rsp_status_q;
  assign used_prio_o   = rsp_prio_q;
  assign occupancy_o   = rsp_occ_q;

endmodule

// File: bench/tb_top.sv
// Testbench for stable_priority_queue: directed and random enqueue/dequeue requests,
// with every response checked against a sorted-queue predictor kept in the bench.
// Depends on spq_pkg, spq_req_if, spq_rsp_if and the stable_priority_queue RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  localparam int unsigned DEPTH       = DEPTH_DEF;
  localparam int unsigned DW          = DATA_WIDTH_DEF;
  localparam int unsigned PW          = PRIO_WIDTH_DEF;
  localparam int unsigned OW          = $clog2(DEPTH_DEF + 1);
  localparam int unsigned RANDOM_REQS = 1500;
  localparam int unsigned TAIL_REQS   = 150;
  localparam int unsigned DRAIN_WAIT  = 25;

  typedef struct {
    logic          kind;
    logic [DW-1:0] payload;
    logic [PW-1:0] prio;
    logic          auto_prio;
    bit            hold;
  } pq_req_t;

  typedef struct {
    logic [DW-1:0] payload;
    status_e       status;
    logic [PW-1:0] used_prio;
    logic [OW-1:0] occupancy;
  } pq_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  spq_req_if req_if ();
  spq_rsp_if rsp_if ();

  stable_priority_queue uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  pq_req_t       req_backlog[$];
  pq_rsp_t       expected_rsp_q[$];
  logic [PW-1:0] held_prio[$];
  logic [DW-1:0] held_data[$];
  logic [PW-1:0] top_prio = '0;
  int unsigned   mismatch_cnt = 0;
  bit            req_taken = 1'b0;
  bit            tail_phase = 1'b0;
  bit            calm = 1'b0;
  int unsigned   calm_cnt = 0;
  int unsigned   gap_cnt = 0;
  int unsigned   stall_cnt = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Sorted queue, front at index 0; ties go behind existing entries.
  function automatic pq_rsp_t pq_apply(logic kind, logic [DW-1:0] payload,
                                       logic [PW-1:0] prio, logic auto_prio);
    pq_rsp_t       res;
    logic [PW-1:0] p;
    int            pos;
    res.payload   = '0;
    res.status    = ST_OK;
    res.used_prio = '0;
    if (kind == KIND_DEQ) begin
      if (held_prio.size() == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.payload = held_data.pop_front();
        void'(held_prio.pop_front());
      end
    end else begin
      p = prio;
      if (auto_prio) begin
        p = (top_prio == '1) ? top_prio : top_prio + 1'b1;
      end
      if (held_prio.size() >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < held_prio.size() && held_prio[pos] >= p) pos++;
        held_prio.insert(pos, p);
        held_data.insert(pos, payload);
        // going to the front resets the maximum, even downward
        if (pos == 0 || p > top_prio) top_prio = p;
        res.used_prio = p;
      end
    end
    res.occupancy = OW'(held_prio.size());
    return res;
  endfunction

  function automatic void add_req(logic kind, logic [DW-1:0] payload, logic [PW-1:0] prio,
                                  logic auto_prio, bit hold);
    req_backlog.push_back(pq_req_t'{kind, payload, prio, auto_prio, hold});
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_cnt++;
    end
  endfunction

  // request accept and prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_taken  <= 1'b0;
      tail_phase <= 1'b0;
    end else begin
      req_taken  <= req_if.valid && req_if.ready;
      tail_phase <= req_backlog.size() < TAIL_REQS;
      if (req_if.valid && req_if.ready) begin
        expected_rsp_q.push_back(pq_apply(req_if.kind, req_if.payload, req_if.prio,
                                          req_if.auto_prio));
      end
    end
  end

  // request driver
  always @(negedge clk_i) begin : drive_req
    pq_req_t nxt;
    if (calm_cnt == 0) begin
      calm     <= ($urandom_range(0, 2) == 0);
      calm_cnt <= $urandom_range(50, 200);
    end else begin
      calm_cnt <= calm_cnt - 1;
    end
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_taken) begin
      if (gap_cnt != 0) begin
        gap_cnt      <= gap_cnt - 1;
        req_if.valid <= 1'b0;
      end else if (req_backlog.size() == 0 ||
                   (req_backlog[0].hold && expected_rsp_q.size() != 0)) begin
        req_if.valid <= 1'b0;
      end else if (!(calm || tail_phase) && $urandom_range(0, 9) == 0) begin
        gap_cnt      <= $urandom_range(0, 7);
        req_if.valid <= 1'b0;
      end else begin
        nxt              = req_backlog.pop_front();
        req_if.valid     <= 1'b1;
        req_if.kind      <= nxt.kind;
        req_if.payload   <= nxt.payload;
        req_if.prio      <= nxt.prio;
        req_if.auto_prio <= nxt.auto_prio;
      end
    end
  end

  // response ready with random stalls
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else if (stall_cnt != 0) begin
      stall_cnt    <= stall_cnt - 1;
      rsp_if.ready <= 1'b0;
    end else if (!(calm || tail_phase) && $urandom_range(0, 7) == 0) begin
      stall_cnt    <= $urandom_range(0, 7);
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_rsp
    pq_rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_rsp_q.size() == 0) begin
        $error("response with no request pending: payload %0h status %0d",
               rsp_if.out_payload, rsp_if.status);
        mismatch_cnt++;
      end else begin
        want = expected_rsp_q.pop_front();
        check_field("out_payload", want.payload, rsp_if.out_payload);
        check_field("status", want.status, rsp_if.status);
        check_field("used_prio", want.used_prio, rsp_if.used_prio);
        check_field("occupancy", want.occupancy, rsp_if.occupancy);
      end
    end
  end

  initial begin : stimulus
    int unsigned   n, j, len, enq_pct, r;
    logic [PW-1:0] p;
    rst_ni           = 1'b0;
    req_if.valid     = 1'b0;
    req_if.kind      = KIND_ENQ;
    req_if.payload   = '0;
    req_if.prio      = '0;
    req_if.auto_prio = 1'b0;
    rsp_if.ready     = 1'b0;

    add_req(KIND_DEQ, '0, '0, 1'b0, 1'b0);                     // empty
    add_req(KIND_ENQ, '1, '1, 1'b0, 1'b0);
    add_req(KIND_ENQ, 32'h1234_5678, 16'h0003, 1'b1, 1'b0);    // auto saturates
    add_req(KIND_ENQ, '0, '0, 1'b0, 1'b0);
    add_req(KIND_DEQ, '1, '1, 1'b1, 1'b0);
    add_req(KIND_DEQ, '0, '0, 1'b0, 1'b0);
    add_req(KIND_ENQ, 32'hA5A5_A5A5, 16'd5, 1'b0, 1'b0);       // front, max drops
    add_req(KIND_ENQ, 32'h5A5A_5A5A, '1, 1'b1, 1'b0);          // auto from lowered max
    add_req(KIND_ENQ, 32'h0F0F_0F0F, 16'd2, 1'b0, 1'b0);       // behind, max kept
    for (n = 0; n < 12; n++) add_req(KIND_ENQ, $urandom, 16'd5, n[0], 1'b0);
    add_req(KIND_ENQ, $urandom, '1, 1'b1, 1'b0);               // full, dropped
    add_req(KIND_DEQ, '0, '0, 1'b0, 1'b0);

    n = 0;
    while (n < RANDOM_REQS) begin
      len = $urandom_range(10, 60);
      case ($urandom_range(0, 3))
        0: enq_pct = 25;
        1: enq_pct = 50;
        2: enq_pct = 70;
        default: enq_pct = 90;
      endcase
      for (j = 0; j < len; j++) begin
        r = $urandom_range(0, 99);
        if (r < 40) p = PW'($urandom_range(0, 7));
        else if (r < 55) p = r[0] ? '1 : PW'($urandom_range(0, 1));
        else p = PW'($urandom);
        add_req(($urandom_range(0, 99) < enq_pct) ? KIND_ENQ : KIND_DEQ, $urandom, p,
                $urandom_range(0, 4) == 0, (n == 0 && j == 0) || $urandom_range(0, 99) == 0);
      end
      n += len;
    end

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (req_backlog.size() != 0 || req_if.valid) @(posedge clk_i);
    while (expected_rsp_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("[stable_priority_queue] OK");
    end else begin
      $display("[stable_priority_queue] ERROR");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("[stable_priority_queue] ERROR");
    $finish;
  end

endmodule
